/* hw/rtl/x86d_pkg.sv */
package x86d_pkg;

    // Decoder phase: which byte of the instruction is expected next.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_MODRM   = 3'd1,
        PH_DISP_LO = 3'd2,
        PH_DISP_HI = 3'd3,
        PH_IMM_LO  = 3'd4,
        PH_IMM_HI  = 3'd5
    } phase_t;

    // Instruction form as reported in a result item.
    typedef enum logic [1:0] {
        FORM_RM      = 2'd0,
        FORM_IMM_REG = 2'd1,
        FORM_IMM_RM  = 2'd2,
        FORM_INVALID = 2'd3
    } form_t;

    // Operation codes.
    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_OR  = 4'd2;
    localparam logic [3:0] OP_ADC = 4'd3;
    localparam logic [3:0] OP_SBB = 4'd4;
    localparam logic [3:0] OP_SUB = 4'd5;
    localparam logic [3:0] OP_AND = 4'd6;
    localparam logic [3:0] OP_XOR = 4'd7;
    localparam logic [3:0] OP_CMP = 4'd8;

    // Opcode patterns on the upper bits of the first byte.
    localparam logic [5:0] OPC_MOV_RM  = 6'b100010;
    localparam logic [5:0] OPC_SUB_RM  = 6'b001010;
    localparam logic [5:0] OPC_CMP_RM  = 6'b001110;
    localparam logic [5:0] OPC_GRP_IMM = 6'b100000;
    localparam logic [3:0] OPC_MOV_IMM = 4'b1011;

    // Special mod/rm values: mod 00 with rm 110 is a direct address.
    localparam logic [1:0] MOD_MEM_NODISP = 2'b00;
    localparam logic [1:0] MOD_MEM_DISP8  = 2'b01;
    localparam logic [1:0] MOD_MEM_DISP16 = 2'b10;
    localparam logic [2:0] RM_DIRECT      = 3'b110;

    // Result payload, held in the output register.
    typedef struct packed {
        logic [3:0]  operation;
        logic [1:0]  form;
        logic        direction;
        logic        wide;
        logic        sign_extend;
        logic [1:0]  mode;
        logic [2:0]  reg_field;
        logic [2:0]  rm_field;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic        invalid;
    } result_t;

    function automatic form_t classify(input logic [7:0] b);
        form_t f;
        if (b[7:2] == OPC_MOV_RM || b[7:2] == OPC_SUB_RM || b[7:2] == OPC_CMP_RM) begin
            f = FORM_RM;
        end else if (b[7:4] == OPC_MOV_IMM) begin
            f = FORM_IMM_REG;
        end else if (b[7:2] == OPC_GRP_IMM) begin
            f = FORM_IMM_RM;
        end else begin
            f = FORM_INVALID;
        end
        return f;
    endfunction

    // Number of displacement bytes that follow a given modrm byte.
    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            MOD_MEM_DISP8:  n = 2'd1;
            MOD_MEM_DISP16: n = 2'd2;
            MOD_MEM_NODISP: n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default:        n = 2'd0;
        endcase
        return n;
    endfunction

    // True when the immediate takes two bytes.
    function automatic logic imm_wide(input logic [7:0] first);
        logic w;
        if (classify(first) == FORM_IMM_REG) begin
            w = first[3];
        end else begin
            w = (first[1:0] == 2'b01);
        end
        return w;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    // Immediate group: modrm reg field to operation.
    function automatic logic [3:0] group_op(input logic [2:0] sel);
        logic [3:0] op;
        case (sel)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_OR;
            3'd2:    op = OP_ADC;
            3'd3:    op = OP_SBB;
            3'd4:    op = OP_AND;
            3'd5:    op = OP_SUB;
            3'd6:    op = OP_XOR;
            default: op = OP_CMP;
        endcase
        return op;
    endfunction

endpackage

/* hw/rtl/x86d_byte_if.sv */
// Channel carrying one code byte per item.
interface x86d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

/* hw/rtl/x86d_insn_if.sv */
// Channel carrying one decoded instruction per item.
interface x86d_insn_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [1:0]  form;
    logic        direction;
    logic        wide;
    logic        sign_extend;
    logic [1:0]  mode;
    logic [2:0]  reg_field;
    logic [2:0]  rm_field;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic        invalid;

    modport source (
        output valid, output operation, output form, output direction, output wide,
        output sign_extend, output mode, output reg_field, output rm_field,
        output displacement, output immediate, output invalid, input ready
    );
    modport sink (
        input valid, input operation, input form, input direction, input wide,
        input sign_extend, input mode, input reg_field, input rm_field,
        input displacement, input immediate, input invalid, output ready
    );
endinterface

/* hw/rtl/x86_16bit_subset_decoder.sv */
// A decoded instruction appears in the output register in the cycle after its last byte is taken.
// Throughput: one code byte per cycle; the phase machine updates in the same cycle a byte lands.
// Output register decouples the sides: a byte is taken while a result waits if it is drained.
// Reset (rst_n, asynchronous, active low) returns to expecting a first byte and clears the halt.
// After an unsupported first byte one invalid item is produced and later bytes are discarded.
module x86_16bit_subset_decoder (
    input  logic                clk,
    input  logic                rst_n,
    x86d_byte_if.sink           code,
    x86d_insn_if.source         decoded
);

    // Decoder state. The byte-holding registers record the parts of the
    // instruction seen so far; the phase says which byte comes next.
    x86d_pkg::phase_t phase_reg, phase_next;
    logic             halted_reg, halted_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       modrm_reg, modrm_next;
    logic [15:0]      disp_reg, disp_next;
    logic [7:0]       imm_low_reg, imm_low_next;

    // Output register and its valid flag.
    x86d_pkg::result_t result_reg, result_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic              emit;
    logic [15:0]       imm_value;
    x86d_pkg::form_t   first_form;
    x86d_pkg::form_t   byte_form;

    // A byte can be taken whenever the output slot is empty or being emptied
    // in this cycle, so a waiting result never blocks the input needlessly.
    assign code.ready = !out_valid_reg || decoded.ready;
    assign accept     = code.valid && code.ready;

    assign first_form = x86d_pkg::classify(first_reg);
    assign byte_form  = x86d_pkg::classify(code.code_byte);

    // Next-state logic of the phase machine.
    always_comb
    begin
        phase_next  = phase_reg;
        halted_next = halted_reg;
        if (accept && !halted_reg) begin
            case (phase_reg)
                x86d_pkg::PH_FIRST:
                begin
                    if (byte_form == x86d_pkg::FORM_INVALID) begin
                        halted_next = 1'b1;
                    end else if (byte_form == x86d_pkg::FORM_IMM_REG) begin
                        phase_next = x86d_pkg::PH_IMM_LO;
                    end else begin
                        phase_next = x86d_pkg::PH_MODRM;
                    end
                end
                x86d_pkg::PH_MODRM:
                begin
                    if (x86d_pkg::disp_len(code.code_byte) != 2'd0) begin
                        phase_next = x86d_pkg::PH_DISP_LO;
                    end else if (first_form == x86d_pkg::FORM_RM) begin
                        phase_next = x86d_pkg::PH_FIRST;
                    end else begin
                        phase_next = x86d_pkg::PH_IMM_LO;
                    end
                end
                x86d_pkg::PH_DISP_LO:
                begin
                    if (x86d_pkg::disp_len(modrm_reg) == 2'd2) begin
                        phase_next = x86d_pkg::PH_DISP_HI;
                    end else if (first_form == x86d_pkg::FORM_RM) begin
                        phase_next = x86d_pkg::PH_FIRST;
                    end else begin
                        phase_next = x86d_pkg::PH_IMM_LO;
                    end
                end
                x86d_pkg::PH_DISP_HI:
                begin
                    if (first_form == x86d_pkg::FORM_RM) begin
                        phase_next = x86d_pkg::PH_FIRST;
                    end else begin
                        phase_next = x86d_pkg::PH_IMM_LO;
                    end
                end
                x86d_pkg::PH_IMM_LO:
                begin
                    if (x86d_pkg::imm_wide(first_reg)) begin
                        phase_next = x86d_pkg::PH_IMM_HI;
                    end else begin
                        phase_next = x86d_pkg::PH_FIRST;
                    end
                end
                x86d_pkg::PH_IMM_HI:
                begin
                    phase_next = x86d_pkg::PH_FIRST;
                end
                default:
                begin
                    phase_next = x86d_pkg::PH_FIRST;
                end
            endcase
        end
    end

    // Field capture and result building. The result is formed from the
    // updated modrm and displacement values, so the byte that completes an
    // instruction is already folded in.
    always_comb
    begin
        first_next   = first_reg;
        modrm_next   = modrm_reg;
        disp_next    = disp_reg;
        imm_low_next = imm_low_reg;
        imm_value    = 16'h0000;
        emit         = 1'b0;
        result_next  = result_reg;

        if (accept && !halted_reg) begin
            case (phase_reg)
                x86d_pkg::PH_FIRST:
                begin
                    first_next   = code.code_byte;
                    modrm_next   = 8'h00;
                    disp_next    = 16'h0000;
                    imm_low_next = 8'h00;
                end
                x86d_pkg::PH_MODRM:
                begin
                    modrm_next = code.code_byte;
                    disp_next  = 16'h0000;
                    emit       = (x86d_pkg::disp_len(code.code_byte) == 2'd0)
                                 && (first_form == x86d_pkg::FORM_RM);
                end
                x86d_pkg::PH_DISP_LO:
                begin
                    disp_next = x86d_pkg::sext8(code.code_byte);
                    emit      = (x86d_pkg::disp_len(modrm_reg) != 2'd2)
                                && (first_form == x86d_pkg::FORM_RM);
                end
                x86d_pkg::PH_DISP_HI:
                begin
                    disp_next = {code.code_byte, disp_reg[7:0]};
                    emit      = (first_form == x86d_pkg::FORM_RM);
                end
                x86d_pkg::PH_IMM_LO:
                begin
                    imm_low_next = code.code_byte;
                    imm_value    = x86d_pkg::sext8(code.code_byte);
                    emit         = !x86d_pkg::imm_wide(first_reg);
                end
                x86d_pkg::PH_IMM_HI:
                begin
                    imm_value = {code.code_byte, imm_low_reg};
                    emit      = 1'b1;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        if (emit) begin
            result_next             = '0;
            result_next.form        = first_form;
            result_next.wide        = (first_form == x86d_pkg::FORM_IMM_REG) ? first_reg[3]
                                                                             : first_reg[0];
            result_next.immediate   = (first_form == x86d_pkg::FORM_RM) ? 16'h0000 : imm_value;
            if (first_form == x86d_pkg::FORM_IMM_REG) begin
                result_next.operation = x86d_pkg::OP_MOV;
                result_next.reg_field = first_reg[2:0];
            end else begin
                result_next.mode         = modrm_next[7:6];
                result_next.rm_field     = modrm_next[2:0];
                result_next.displacement = disp_next;
                if (first_form == x86d_pkg::FORM_RM) begin
                    result_next.direction = first_reg[1];
                    result_next.reg_field = modrm_next[5:3];
                    if (first_reg[7:2] == x86d_pkg::OPC_MOV_RM) begin
                        result_next.operation = x86d_pkg::OP_MOV;
                    end else if (first_reg[7:2] == x86d_pkg::OPC_SUB_RM) begin
                        result_next.operation = x86d_pkg::OP_SUB;
                    end else begin
                        result_next.operation = x86d_pkg::OP_CMP;
                    end
                end else begin
                    result_next.sign_extend = first_reg[1];
                    result_next.operation   = x86d_pkg::group_op(modrm_next[5:3]);
                end
            end
        end else if (accept && !halted_reg && phase_reg == x86d_pkg::PH_FIRST
                     && byte_form == x86d_pkg::FORM_INVALID) begin
            // Unsupported opcode: a single item flagged invalid, all else zero.
            result_next         = '0;
            result_next.invalid = 1'b1;
        end
    end

    // The output register loads on a new result, else empties once taken.
    always_comb
    begin
        if (accept && !halted_reg && (emit || halted_next)) begin
            out_valid_next = 1'b1;
        end else if (decoded.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= x86d_pkg::PH_FIRST;
            halted_reg    <= 1'b0;
            first_reg     <= 8'h00;
            modrm_reg     <= 8'h00;
            disp_reg      <= 16'h0000;
            imm_low_reg   <= 8'h00;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            halted_reg    <= halted_next;
            first_reg     <= first_next;
            modrm_reg     <= modrm_next;
            disp_reg      <= disp_next;
            imm_low_reg   <= imm_low_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload needs no reset; it is only looked at while the valid flag is set.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign decoded.valid        = out_valid_reg;
    assign decoded.operation    = result_reg.operation;
    assign decoded.form         = result_reg.form;
    assign decoded.direction    = result_reg.direction;
    assign decoded.wide         = result_reg.wide;
    assign decoded.sign_extend  = result_reg.sign_extend;
    assign decoded.mode         = result_reg.mode;
    assign decoded.reg_field    = result_reg.reg_field;
    assign decoded.rm_field     = result_reg.rm_field;
    assign decoded.displacement = result_reg.displacement;
    assign decoded.immediate    = result_reg.immediate;
    assign decoded.invalid      = result_reg.invalid;

endmodule
